// ===== design/syn_flood_flow_counter_assert.svh =====
// Assertion helpers for the SYN flood flow counter.
// Both expect clk and rst_n in scope of the module that uses them.
`ifndef SYN_FLOOD_FLOW_COUNTER_ASSERT_SVH
`define SYN_FLOOD_FLOW_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define SFFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sffc_pkg.sv =====
// ----------------------------------------------------------------------------
// sffc_pkg
// Types and constants shared by the SYN flood flow counter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sffc_pkg;

  localparam int LANES  = 16;
  localparam int LANE_W = 4;
  localparam int KEY_W  = 48;

  localparam logic [7:0] TCP_PROTO = 8'd6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYN_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd2;

  localparam logic [31:0] LOCAL_ADDR_RST = 32'd0;
  localparam logic [15:0] SYN_LIMIT_RST  = 16'd20;
  localparam logic [15:0] WINDOW_RST     = 16'd5;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] dest_port;
    logic        syn_flag;
    logic        ack_flag;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic        counted;
    logic        alarm;
    logic [15:0] flow_count;
    logic        table_full;
  } out_t;

  // Flow key: source address and destination port.
  typedef logic [KEY_W-1:0] key_t;

  // Result of comparing one row of keys.
  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } match_t;

endpackage

`default_nettype wire

// ===== design/sffc_key_bank.sv =====
// ----------------------------------------------------------------------------
// sffc_key_bank
// Flow keys stored in sixteen lane memories; one row read per cycle while
// rd_en is set and compared against the lookup key in the lanes of lane_mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sffc_key_bank #(
  parameter int ROWS = 64,
  parameter int RAW  = 6
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [RAW-1:0]             rd_row,
  input  logic                       wr_en,
  input  logic [RAW-1:0]             wr_row,
  input  logic [sffc_pkg::LANE_W-1:0] wr_lane,
  input  sffc_pkg::key_t             wr_key,
  input  sffc_pkg::key_t             look_key,
  input  logic [sffc_pkg::LANES-1:0] lane_mask,
  output sffc_pkg::match_t           match
);
  import sffc_pkg::*;

  logic [LANES-1:0] hit_vec;

  for (genvar l = 0; l < LANES; l++) begin : lane_g
    key_t mem [0:ROWS-1];
    key_t rd_q;

    always_ff @(posedge clk) begin
      if (wr_en && wr_lane == LANE_W'(l)) begin
        mem[wr_row] <= wr_key;
      end
      if (rd_en) begin
        rd_q <= mem[rd_row];
      end
    end

    assign hit_vec[l] = lane_mask[l] && (rd_q == look_key);
  end

  // lowest lane wins
  always_comb begin
    match.hit  = |hit_vec;
    match.lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hit_vec[l]) begin
        match.lane = LANE_W'(l);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/syn_flood_flow_counter.sv =====
// Counts pure TCP SYNs (SYN set, ACK clear) sent to local_addr, per flow of
// source address and destination port, over a fixed window per flow, and
// returns one result per packet. For a counted packet the flow search,
// skipped while the table is empty, reads one row of 16 keys a cycle from
// the key memory and compares them in parallel, then the count and window
// start are read, updated and written back. One packet is worked on at a
// time; the next one is taken while the previous result still waits in the
// output register. Flows are appended and never removed; once TABLE_DEPTH
// flows are stored a new flow is dropped and flagged with table_full.
`timescale 1ns / 1ps
`default_nettype none

`include "syn_flood_flow_counter_assert.svh"

// ----------------------------------------------------------------------------
// syn_flood_flow_counter
// Per-flow SYN counter with fixed-window alarm and flow table in memory.
// ----------------------------------------------------------------------------
module syn_flood_flow_counter #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sffc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sffc_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [sffc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sffc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sffc_pkg::*;

  localparam int ROWS = (TABLE_DEPTH + LANES - 1) / LANES;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EW   = RAW + LANE_W;
  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MISS = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // configuration
  logic [31:0] local_addr_r;
  logic [15:0] syn_limit_r;
  logic [15:0] window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= LOCAL_ADDR_RST;
      syn_limit_r  <= SYN_LIMIT_RST;
      window_r     <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL_ADDR: local_addr_r <= cfg_wdata;
        REG_SYN_LIMIT:  syn_limit_r  <= cfg_wdata[15:0];
        REG_WINDOW:     window_r     <= cfg_wdata[15:0];
        default:        ;
      endcase
    end
  end

  logic [2:0]    state_r, state_nxt;
  in_t           item_r, item_nxt;
  logic [RAW:0]  row_r, row_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [RAW-1:0] cmp_row_r, cmp_row_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] used_r, used_nxt;
  out_t          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  // entry memory: {syn count, window start}
  logic [47:0]   dmem [0:TABLE_DEPTH-1];
  logic [47:0]   drd_r;
  logic          dwr_en;
  logic [IW-1:0] dwr_idx;
  logic [47:0]   dwr_data;

  logic             pure_syn;
  logic             issue;
  logic [EW-1:0]    used_e;
  logic [LANES-1:0] lane_mask;
  match_t           match;
  logic             kwr_en;
  logic [31:0]      elapsed;
  logic [15:0]      new_count;
  logic             restart;

  assign pure_syn = (in_data.protocol == TCP_PROTO) && (in_data.dst_addr == local_addr_r) &&
                    in_data.syn_flag && !in_data.ack_flag;

  assign used_e = EW'(used_r);
  assign issue  = (state_r == ST_SCAN) &&
                  (((32'(row_r)) << LANE_W) < 32'(used_r));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_mask[l] = ((32'(cmp_row_r) << LANE_W) + 32'(l)) < 32'(used_r);
    end
  end

  assign kwr_en = (state_r == ST_MISS) && (used_r != FULL);

  sffc_key_bank #(
    .ROWS (ROWS),
    .RAW  (RAW)
  ) u_key_bank (
    .clk       (clk),
    .rd_en     (issue),
    .rd_row    (row_r[RAW-1:0]),
    .wr_en     (kwr_en),
    .wr_row    (used_e[EW-1:LANE_W]),
    .wr_lane   (used_e[LANE_W-1:0]),
    .wr_key    ({item_r.src_addr, item_r.dest_port}),
    .look_key  ({item_r.src_addr, item_r.dest_port}),
    .lane_mask (lane_mask),
    .match     (match)
  );

  assign elapsed   = item_r.now_seconds - drd_r[31:0];
  assign restart   = elapsed > {16'd0, window_r};
  assign new_count = restart ? 16'd1 :
                     (drd_r[47:32] == 16'hFFFF) ? 16'hFFFF : drd_r[47:32] + 16'd1;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    row_nxt       = row_r;
    cmp_v_nxt     = 1'b0;
    cmp_row_nxt   = cmp_row_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    dwr_en        = 1'b0;
    dwr_idx       = idx_r;
    dwr_data      = {new_count, restart ? item_r.now_seconds : drd_r[31:0]};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          row_nxt  = '0;
          if (!pure_syn) begin
            state_nxt = ST_DONE;
          end else if (used_r == '0) begin
            state_nxt = ST_MISS;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one row per cycle, compare the row read the cycle before
        if (issue) begin
          row_nxt     = row_r + 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_row_nxt = row_r[RAW-1:0];
        end
        if (cmp_v_r && match.hit) begin
          idx_nxt   = IW'({cmp_row_r, match.lane});
          state_nxt = ST_RD;
        end else if (!issue && !cmp_v_r) begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        res_nxt.counted = 1'b1;
        if (used_r == FULL) begin
          res_nxt.table_full = 1'b1;
        end else begin
          dwr_en             = 1'b1;
          dwr_idx            = IW'(used_r);
          dwr_data           = {16'd1, item_r.now_seconds};
          used_nxt           = used_r + 1'b1;
          res_nxt.flow_count = 16'd1;
        end
        state_nxt = ST_DONE;
      end
      ST_RD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        dwr_en             = 1'b1;
        res_nxt.counted    = 1'b1;
        res_nxt.flow_count = new_count;
        res_nxt.alarm      = new_count >= syn_limit_r;
        state_nxt          = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_v_r     <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_v_r     <= cmp_v_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    row_r     <= row_nxt;
    cmp_row_r <= cmp_row_nxt;
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (dwr_en) begin
      dmem[dwr_idx] <= dwr_data;
    end
    if (state_r == ST_RD) begin
      drd_r <= dmem[idx_r];
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SFFC_ASSERT_NOW(a_used_bound, 1'b1, used_r <= FULL, "flow count above table depth")
  `SFFC_ASSERT_NEXT(a_used_only_on_miss, rst_n && state_r != ST_MISS,
                    used_r == $past(used_r), "flow count changed outside append")
  `SFFC_ASSERT_NOW(a_ignored_zero, out_valid_r && !out_r.counted,
                   out_r.flow_count == 16'd0 && !out_r.alarm && !out_r.table_full,
                   "uncounted packet with nonzero result")
  `SFFC_ASSERT_NOW(a_full_flag, out_valid_r && out_r.table_full, used_r == FULL,
                   "table_full reported with free entries")

endmodule

`default_nettype wire
